// ===== src/stq_pkg.sv =====
package stq_pkg;

    localparam int QUEUE_DEPTH = 16;

    localparam int TIME_W     = 48;
    localparam int ID_W       = 16;
    localparam int ATT_W      = 8;
    localparam int MODE_W     = 2;
    localparam int STATUS_W   = 2;

    // s_tdata: now_time, delay, socket_id, buffer_id, old_expiry, old_attempts
    localparam int S_TDATA_W  = 184;
    // m_tdata: out_socket, out_buffer, out_expiry, out_attempts
    localparam int M_TDATA_W  = 88;

    typedef enum logic [MODE_W-1:0] {
        MODE_REGISTER = 2'd0,
        MODE_REFRESH  = 2'd1,
        MODE_POLL     = 2'd2,
        MODE_UNUSED   = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_NONE     = 2'd2,
        ST_POPPED   = 2'd3
    } status_t;

    typedef struct packed {
        logic [TIME_W-1:0] expiry;
        logic [ID_W-1:0]   socket;
        logic [ID_W-1:0]   buffer;
        logic [ATT_W-1:0]  attempts;
    } entry_t;

    // One command per cycle for the whole row of cells
    typedef struct packed {
        logic ins;
        logic pop;
    } cell_ctrl_t;

endpackage

// ===== src/stq_cell.sv =====
module stq_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  stq_pkg::cell_ctrl_t ctrl,
    input  stq_pkg::entry_t    new_entry,
    input  logic               left_valid,
    input  logic               left_after,
    input  stq_pkg::entry_t    left_entry,
    input  logic               right_valid,
    input  stq_pkg::entry_t    right_entry,
    output logic               valid,
    output logic               after,
    output stq_pkg::entry_t    entry
);
    import stq_pkg::*;

    logic   valid_reg, valid_next;
    entry_t entry_reg, entry_next;

    // At or after the insert point: empty, or holds an equal or later expiry
    assign after = !valid_reg || (entry_reg.expiry >= new_entry.expiry);

    always_comb begin
        valid_next = valid_reg;
        entry_next = entry_reg;
        if (ctrl.ins) begin
            if (left_after) begin
                valid_next = left_valid;
                entry_next = left_entry;
            end else if (after) begin
                valid_next = 1'b1;
                entry_next = new_entry;
            end
        end else if (ctrl.pop) begin
            valid_next = right_valid;
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign valid = valid_reg;
    assign entry = entry_reg;

endmodule

// ===== src/sorted_expiry_timer_queue.sv =====
// The result item of an accepted item is registered and is on m_* in the cycle after acceptance.
// Throughput: one item per cycle while m_* is not stalled; insert, shift and pop all
// complete together in the registers of the cell row, so the next item sees the updated queue at once.
// s_tready falls only while a result item waits unread on m_*.
// Reset (aresetn low, synchronous): queue empty, no result pending; slot contents
// are left as they are and are never read before being written.
module sorted_expiry_timer_queue (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [47:0] now_time, [95:48] delay, [111:96] socket_id, [127:112] buffer_id,
    // [175:128] old_expiry, [183:176] old_attempts
    input  logic [stq_pkg::S_TDATA_W-1:0]  s_tdata,
    // [1:0] mode
    input  logic [stq_pkg::MODE_W-1:0]     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [15:0] out_socket, [31:16] out_buffer, [79:32] out_expiry, [87:80] out_attempts
    output logic [stq_pkg::M_TDATA_W-1:0]  m_tdata,
    // [1:0] status
    output logic [stq_pkg::STATUS_W-1:0]   m_tuser
);
    import stq_pkg::*;

    // Unpack the input item
    mode_t              in_mode;
    logic [TIME_W-1:0]  in_now;
    logic [TIME_W-1:0]  in_delay;
    logic [ID_W-1:0]    in_socket;
    logic [ID_W-1:0]    in_buffer;
    logic [TIME_W-1:0]  in_old_expiry;
    logic [ATT_W-1:0]   in_old_attempts;

    assign in_mode         = mode_t'(s_tuser);
    assign in_now          = s_tdata[47:0];
    assign in_delay        = s_tdata[95:48];
    assign in_socket       = s_tdata[111:96];
    assign in_buffer       = s_tdata[127:112];
    assign in_old_expiry   = s_tdata[175:128];
    assign in_old_attempts = s_tdata[183:176];

    // Result register
    logic                 m_valid_reg, m_valid_next;
    status_t              status_reg, status_next;
    entry_t               out_reg, out_next;

    logic s_fire;
    assign s_tready = !m_valid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;

    // Cell row
    entry_t                 cell_entry [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] cell_valid;
    logic [QUEUE_DEPTH-1:0] cell_after;
    cell_ctrl_t             ctrl;
    entry_t                 new_entry;

    // Expiry of the timer to insert: base plus delay, saturating at the top of the range
    logic [TIME_W-1:0] base_time;
    logic [TIME_W:0]   exp_sum;
    logic [ATT_W-1:0]  new_attempts;
    logic              is_insert_mode;
    logic              queue_full;
    logic              head_due;

    assign base_time = (in_mode == MODE_REFRESH) ? in_old_expiry : in_now;
    assign exp_sum   = {1'b0, base_time} + {1'b0, in_delay};

    always_comb begin
        new_attempts = '0;
        if (in_mode == MODE_REFRESH) begin
            new_attempts = (in_old_attempts == {ATT_W{1'b1}}) ? in_old_attempts
                                                                : in_old_attempts + ATT_W'(1);
        end
    end

    assign new_entry.expiry   = exp_sum[TIME_W] ? {TIME_W{1'b1}} : exp_sum[TIME_W-1:0];
    assign new_entry.socket   = in_socket;
    assign new_entry.buffer   = in_buffer;
    assign new_entry.attempts = new_attempts;

    assign is_insert_mode = (in_mode == MODE_REGISTER) || (in_mode == MODE_REFRESH);
    assign queue_full     = cell_valid[QUEUE_DEPTH-1];
    // Pop only when now is strictly past the head expiry
    assign head_due       = cell_valid[0] && (in_now > cell_entry[0].expiry);

    assign ctrl.ins = s_fire && is_insert_mode && !queue_full;
    assign ctrl.pop = s_fire && (in_mode == MODE_POLL) && head_due;

    // Each cell takes the new timer at the insert point, its left neighbour's
    // timer beyond it, or its right neighbour's timer on a pop
    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        logic   left_valid, left_after, right_valid;
        entry_t left_entry, right_entry;

        if (i == 0) begin : g_head
            assign left_valid = 1'b0;
            assign left_after = 1'b0;
            assign left_entry = new_entry;
        end else begin : g_body
            assign left_valid = cell_valid[i-1];
            assign left_after = cell_after[i-1];
            assign left_entry = cell_entry[i-1];
        end

        if (i == QUEUE_DEPTH - 1) begin : g_tail
            assign right_valid = 1'b0;
            assign right_entry = cell_entry[i];
        end else begin : g_inner
            assign right_valid = cell_valid[i+1];
            assign right_entry = cell_entry[i+1];
        end

        stq_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .new_entry   (new_entry),
            .left_valid  (left_valid),
            .left_after  (left_after),
            .left_entry  (left_entry),
            .right_valid (right_valid),
            .right_entry (right_entry),
            .valid       (cell_valid[i]),
            .after       (cell_after[i]),
            .entry       (cell_entry[i])
        );
    end

    // Build the result item; fields stay zero unless a timer is popped
    always_comb begin
        m_valid_next = m_valid_reg;
        status_next  = status_reg;
        out_next     = out_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (s_fire) begin
            m_valid_next = 1'b1;
            out_next     = '0;
            unique case (in_mode)
                MODE_REGISTER,
                MODE_REFRESH: begin
                    status_next = queue_full ? ST_FULL : ST_INSERTED;
                end
                MODE_POLL: begin
                    if (head_due) begin
                        status_next = ST_POPPED;
                        out_next    = cell_entry[0];
                    end else begin
                        status_next = ST_NONE;
                    end
                end
                default: begin
                    status_next = ST_NONE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        out_reg    <= out_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {out_reg.attempts, out_reg.expiry, out_reg.buffer, out_reg.socket};

    // Occupied cells always form an unbroken run from the head
    a_valid_prefix: assert property (@(posedge aclk) disable iff (!aresetn)
        ((cell_valid + QUEUE_DEPTH'(1)) & cell_valid) == '0)
        else $error("occupied cells are not contiguous from the head");

    // The two front timers stay in expiry order
    a_head_sorted: assert property (@(posedge aclk) disable iff (!aresetn)
        cell_valid[1] |-> (cell_entry[0].expiry <= cell_entry[1].expiry))
        else $error("head timers out of order");

    // An insert into a full queue is rejected and leaves the queue unchanged
    a_full_reject: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && is_insert_mode && queue_full)
        |=> (m_tuser == ST_FULL) && (cell_valid == $past(cell_valid)))
        else $error("insert into a full queue not rejected");

    // A pop removes exactly one timer
    a_pop_count: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.pop |=> ($countones(cell_valid) + 1 == $countones($past(cell_valid))))
        else $error("pop did not remove exactly one timer");

    // Only a popped timer carries data
    a_zero_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser != ST_POPPED)) |-> (m_tdata == '0))
        else $error("non-pop result carries data");

endmodule

// ===== test/tb_sorted_expiry_timer_queue.sv =====
`timescale 1ns / 100ps

module tb_sorted_expiry_timer_queue;
    import stq_pkg::*;

    localparam logic [TIME_W-1:0] TICK_MAX    = '1;
    localparam int                HOLD_CYCLES = 300;
    localparam int                PHASE_ITEMS = 330;

    // One command to the timer queue, as the sender offers it
    typedef struct packed {
        mode_t             mode;
        logic [TIME_W-1:0] now_t;
        logic [TIME_W-1:0] delay;
        logic [ID_W-1:0]   sock;
        logic [ID_W-1:0]   bid;
        logic [TIME_W-1:0] old_exp;
        logic [ATT_W-1:0]  old_att;
    } timer_cmd_t;

    // One answer from the queue
    typedef struct packed {
        status_t           status;
        logic [ID_W-1:0]   sock;
        logic [ID_W-1:0]   bid;
        logic [TIME_W-1:0] expiry;
        logic [ATT_W-1:0]  att;
    } timer_ans_t;

    // Directed row: repeated reps times, socket rising and delay falling by one per copy
    typedef struct packed {
        timer_cmd_t cmd;
        int         reps;
        bit         typed;
        timer_ans_t want;
    } stim_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [MODE_W-1:0]    s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]  m_tuser;

    // Shadow copy of the queue contents
    entry_t     timer_row[QUEUE_DEPTH];
    int         timer_count = 0;
    entry_t     recent_pops[$];
    timer_ans_t awaiting_answers[$];
    stim_row_t  stim_table[$];

    int          mismatches = 0;
    int          items_sent = 0;
    int          answers_checked = 0;
    int          pops_seen = 0;
    int          rejects_seen = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_ticket = 0;
    int          hold_seen = 0;
    int          hold_left = 0;
    logic [TIME_W-1:0] tick_now = 48'h1000;

    sorted_expiry_timer_queue uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [TIME_W-1:0] rand48();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[TIME_W-1:0];
    endfunction

    function automatic logic [TIME_W-1:0] add_sat48(input logic [TIME_W-1:0] a,
                                                    input logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? TICK_MAX : s[TIME_W-1:0];
    endfunction

    // Apply one command to the shadow queue and return the answer it earns
    function automatic timer_ans_t apply_timer_cmd(input timer_cmd_t c);
        timer_ans_t        r;
        entry_t            e;
        int                slot;
        int                i;
        r = '0;
        r.status = ST_NONE;
        if (c.mode == MODE_REGISTER || c.mode == MODE_REFRESH) begin
            if (c.mode == MODE_REGISTER) begin
                e.expiry   = add_sat48(c.now_t, c.delay);
                e.attempts = '0;
            end else begin
                e.expiry   = add_sat48(c.old_exp, c.delay);
                e.attempts = (c.old_att == '1) ? c.old_att : c.old_att + 8'd1;
            end
            e.socket = c.sock;
            e.buffer = c.bid;
            if (timer_count >= QUEUE_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                // land ahead of the first timer that expires no earlier
                slot = timer_count;
                for (i = timer_count - 1; i >= 0; i--)
                    if (timer_row[i].expiry >= e.expiry)
                        slot = i;
                for (i = timer_count; i > slot; i--)
                    timer_row[i] = timer_row[i-1];
                timer_row[slot] = e;
                timer_count++;
                r.status = ST_INSERTED;
            end
        end else if (c.mode == MODE_POLL && timer_count > 0 &&
                     c.now_t > timer_row[0].expiry) begin
            e = timer_row[0];
            r.status = ST_POPPED;
            r.sock   = e.socket;
            r.bid    = e.buffer;
            r.expiry = e.expiry;
            r.att    = e.attempts;
            for (i = 1; i < timer_count; i++)
                timer_row[i-1] = timer_row[i];
            timer_count--;
            // keep a handful of popped timers around for refresh traffic
            if (recent_pops.size() < 32)
                recent_pops.push_back(e);
        end
        return r;
    endfunction

    function automatic void add_row(input mode_t m, input logic [TIME_W-1:0] now_t,
                                    input logic [TIME_W-1:0] dly, input logic [ID_W-1:0] sock,
                                    input logic [ID_W-1:0] bid, input logic [TIME_W-1:0] oexp,
                                    input logic [ATT_W-1:0] oatt, input int reps,
                                    input bit typed, input status_t st,
                                    input logic [ID_W-1:0] rsock, input logic [ID_W-1:0] rbid,
                                    input logic [TIME_W-1:0] rexp,
                                    input logic [ATT_W-1:0] ratt);
        stim_row_t row;
        row.cmd         = '{m, now_t, dly, sock, bid, oexp, oatt};
        row.reps        = reps;
        row.typed       = typed;
        row.want.status = st;
        row.want.sock   = rsock;
        row.want.bid    = rbid;
        row.want.expiry = rexp;
        row.want.att    = ratt;
        stim_table.push_back(row);
    endfunction

    // Mostly well-formed traffic on a rising clock; a share of raw noise on every field
    function automatic timer_cmd_t next_random_cmd();
        timer_cmd_t c;
        entry_t     e;
        int         pick;
        int         idx;
        c.mode    = mode_t'(2'($urandom));
        c.now_t   = rand48();
        c.delay   = rand48();
        c.sock    = 16'($urandom);
        c.bid     = 16'($urandom);
        c.old_exp = rand48();
        c.old_att = 8'($urandom);
        pick = $urandom_range(99);
        if (pick < 35) begin
            c.mode  = MODE_REGISTER;
            c.now_t = tick_now;
            c.delay = 48'($urandom_range(300));
        end else if (pick < 50) begin
            c.mode  = MODE_REFRESH;
            c.delay = 48'($urandom_range(300, 1));
            c.old_exp = tick_now;
            if (recent_pops.size() > 0) begin
                idx = $urandom_range(recent_pops.size() - 1);
                e = recent_pops[idx];
                recent_pops.delete(idx);
                c.sock    = e.socket;
                c.bid     = e.buffer;
                c.old_exp = e.expiry;
                c.old_att = e.attempts;
            end
        end else if (pick < 85) begin
            c.mode  = MODE_POLL;
            c.now_t = tick_now;
        end
        tick_now = tick_now + 48'($urandom_range(40));
        return c;
    endfunction

    // Offer one item, hold it until taken, then log what it should produce
    task automatic send_timer_cmd(input timer_cmd_t c, input bit typed, input timer_ans_t want);
        timer_ans_t pred;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= c.mode;
        s_tdata  <= {c.old_att, c.old_exp, c.bid, c.sock, c.delay, c.now_t};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        pred = apply_timer_cmd(c);
        awaiting_answers.push_back(typed ? want : pred);
        items_sent++;
    endtask

    // Drop valid and wait for every outstanding answer
    task automatic drain_answers();
        s_tvalid <= 1'b0;
        while (awaiting_answers.size() != 0)
            @(posedge aclk);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("tb: mismatch on answer %0d, %s: got %0h, expected %0h",
                 answers_checked, what, got, want);
        mismatches++;
    endtask

    // Receiver: random back-pressure, plus a long hold-off whenever a new ticket appears
    always @(posedge aclk) begin
        if (hold_seen != hold_ticket) begin
            hold_seen = hold_ticket;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compare every answer taken against the oldest one logged
    always @(posedge aclk) begin
        timer_ans_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (awaiting_answers.size() == 0) begin
                report_mismatch("answer with none pending", 64'(m_tuser), 64'(m_tdata));
            end else begin
                want = awaiting_answers.pop_front();
                if (m_tuser != want.status)
                    report_mismatch("status", 64'(m_tuser), 64'(want.status));
                if (m_tdata[15:0] != want.sock)
                    report_mismatch("out_socket", 64'(m_tdata[15:0]), 64'(want.sock));
                if (m_tdata[31:16] != want.bid)
                    report_mismatch("out_buffer", 64'(m_tdata[31:16]), 64'(want.bid));
                if (m_tdata[79:32] != want.expiry)
                    report_mismatch("out_expiry", 64'(m_tdata[79:32]), 64'(want.expiry));
                if (m_tdata[87:80] != want.att)
                    report_mismatch("out_attempts", 64'(m_tdata[87:80]), 64'(want.att));
                if (want.status == ST_POPPED)
                    pops_seen++;
                if (want.status == ST_FULL)
                    rejects_seen++;
            end
            answers_checked++;
        end
    end

    initial begin
        #2_000_000;
        $display("tb: run timed out with %0d answers outstanding", awaiting_answers.size());
        $display("tb: failure");
        $finish;
    end

    initial begin
        stim_row_t  row;
        timer_cmd_t c;
        int         k;
        int         p;
        int         n;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed table: empty queue, unused mode, saturation, ties, strict expiry, full queue
        add_row(MODE_POLL, TICK_MAX, 0, 0, 0, 0, 0, 1, 1, ST_NONE, 0, 0, 0, 0);
        add_row(MODE_UNUSED, TICK_MAX, TICK_MAX, '1, '1, TICK_MAX, '1, 1, 1, ST_NONE,
                0, 0, 0, 0);
        add_row(MODE_REGISTER, TICK_MAX, TICK_MAX, '1, '1, 0, 0, 1, 1, ST_INSERTED,
                0, 0, 0, 0);
        add_row(MODE_REGISTER, 0, 0, 0, 0, 0, 0, 1, 1, ST_INSERTED, 0, 0, 0, 0);
        add_row(MODE_POLL, 0, 0, 0, 0, 0, 0, 1, 1, ST_NONE, 0, 0, 0, 0);
        add_row(MODE_POLL, 1, 0, 0, 0, 0, 0, 1, 1, ST_POPPED, 0, 0, 0, 0);
        add_row(MODE_REFRESH, 0, 10, 16'h1234, 16'h5678, TICK_MAX - 5, '1, 1, 1, ST_INSERTED,
                0, 0, 0, 0);
        add_row(MODE_REFRESH, 0, 0, 16'h0100, 16'h0200, 100, 8'd254, 1, 1, ST_INSERTED,
                0, 0, 0, 0);
        // equal expiry: the newcomer goes ahead of the stored timer
        add_row(MODE_REGISTER, 40, 60, 16'hAAAA, 16'h5555, 0, 0, 1, 0, ST_INSERTED,
                0, 0, 0, 0);
        add_row(MODE_POLL, 100, 0, 0, 0, 0, 0, 1, 1, ST_NONE, 0, 0, 0, 0);
        add_row(MODE_POLL, 101, 0, 0, 0, 0, 0, 1, 0, ST_NONE, 0, 0, 0, 0);
        add_row(MODE_POLL, 101, 0, 0, 0, 0, 0, 1, 1, ST_POPPED, 16'h0100, 16'h0200, 100, '1);
        // fill to the brim, newest first in line, then knock on a full queue
        add_row(MODE_REGISTER, 5000, 900, 16'h2000, 16'h3000, 0, 0, 14, 1, ST_INSERTED,
                0, 0, 0, 0);
        add_row(MODE_REGISTER, 0, 0, 16'h4000, 16'h4001, 0, 0, 1, 1, ST_FULL, 0, 0, 0, 0);
        add_row(MODE_REFRESH, 0, 0, 16'h4002, 16'h4003, 0, 0, 1, 1, ST_FULL, 0, 0, 0, 0);
        add_row(MODE_POLL, 48'h8000, 0, 0, 0, 0, 0, 3, 0, ST_NONE, 0, 0, 0, 0);

        foreach (stim_table[i]) begin
            row = stim_table[i];
            for (k = 0; k < row.reps; k++) begin
                c       = row.cmd;
                c.sock  = c.sock + 16'(k);
                c.delay = c.delay - 48'(k);
                send_timer_cmd(c, row.typed, row.want);
            end
        end
        drain_answers();

        // Random traffic across the idling phases; the sender waits for all answers between
        for (p = 0; p < 4; p++) begin
            case (p)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct <= 0;
                end
                1: begin
                    send_idle_pct = 52;
                    recv_stall_pct <= 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct <= 52;
                end
                default: begin
                    send_idle_pct = 19;
                    recv_stall_pct <= 19;
                end
            endcase
            for (n = 0; n < PHASE_ITEMS; n++) begin
                // hold off the receiver for a long stretch so the input backs up
                if (p == 0 && n == 100)
                    hold_ticket <= hold_ticket + 1;
                send_timer_cmd(next_random_cmd(), 1'b0, '0);
            end
            drain_answers();
        end

        repeat (10) @(posedge aclk);

        $display("tb: %0d items sent, %0d answers checked, %0d timers popped, %0d full rejects",
                 items_sent, answers_checked, pops_seen, rejects_seen);
        $display("tb: directed edge cases, then random traffic under four idling patterns");
        if (mismatches == 0 && awaiting_answers.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
